// ----- design/tempo_synced_step_selector_defines.svh -----
// Assertion macros for the tempo-synced step selector.
// Included by every file that carries concurrent checks; needs nothing else.
`ifndef TEMPO_SYNCED_STEP_SELECTOR_DEFINES_SVH
`define TEMPO_SYNCED_STEP_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside of reset.
`define TSSEL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tssel: property violated");
// Check a property on every rising edge, reset included.
`define TSSEL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tssel: property violated");
`else
`define TSSEL_ASSERT(lbl, clk, rst_n, prop)
`define TSSEL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/tssel_pkg.sv -----
// Shared types, widths and constants of the tempo-synced step selector.
// No dependencies; compile first after the macro header.
package tssel_pkg;

  localparam int POS_W      = 48;  // host position in ticks, signed
  localparam int RATE_W     = 5;
  localparam int CNT_W      = 4;
  localparam int OFF_W      = 8;   // one offset byte
  localparam int LVL_W      = 8;   // one level byte
  localparam int REG_STEPS  = 8;   // steps held by the offset and level registers
  localparam int STEP_IDX_W = 3;
  localparam int OFFS_W     = REG_STEPS * OFF_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int DEF_MAX_STEPS      = 8;
  localparam int DEF_TICKS_PER_BEAT = 768;

  localparam int NUM_RATES     = 18;
  localparam int FALLBACK_RATE = 12;  // 1/16 straight

  localparam logic [RATE_W-1:0]     RST_RATE  = RATE_W'(12);
  localparam logic [CNT_W-1:0]      RST_COUNT = CNT_W'(8);

  // Note lengths in 96ths of a beat: 4/1, 2/1, 1/1, then straight/triplet/dotted.
  localparam int unsigned LEN96_TAB [NUM_RATES] = '{
    1536, 768, 384,
    192, 128, 288,
    96, 64, 144,
    48, 32, 72,
    24, 16, 36,
    12, 8, 18
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE    = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_OFFSETS = 2'd2,
    CFG_LEVELS  = 2'd3
  } tssel_cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_OUT
  } tssel_state_t;

  // Result of one window scan.
  typedef struct packed {
    logic                  done;
    logic                  hit;
    logic [STEP_IDX_W-1:0] idx;
  } tssel_scan_res_t;

endpackage

// ----- design/tssel_ifs.sv -----
// Valid/ready channel interfaces for position items and step result items.
// Depends on tssel_pkg.
interface tssel_in_if;
  import tssel_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] beat_position;

  modport source (output valid, output beat_position, input ready);
  modport sink (input valid, input beat_position, output ready);
endinterface

interface tssel_out_if;
  import tssel_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STEP_IDX_W-1:0] step_index;
  logic                  step_valid;
  logic [LVL_W-1:0]      step_level;
  logic                  matched;

  modport source (output valid, output step_index, output step_valid,
                  output step_level, output matched, input ready);
  modport sink (input valid, input step_index, input step_valid,
                input step_level, input matched, output ready);
endinterface

// ----- design/tempo_synced_step_selector.sv -----
// Tempo-synced step selector: channel handling, configuration, held step state.
// Depends on tssel_pkg, tssel_ifs, tssel_mod, tssel_scan and the macro header.
//
// Usage:
//   in_chan carries one host position (ticks, TICKS_PER_BEAT per beat, signed)
//   per item; out_chan returns exactly one item per position: the held step,
//   whether any step has matched since reset, that step's level and whether
//   this position hit a step window. cfg_we/cfg_index/cfg_wdata write the rate,
//   step count, offset and level registers; write them only while idle.
//   After an item is accepted, it passes through the bit-serial remainder over
//   all 48 position bits, a floor fix-up, a hand-over into the window scan,
//   one scan step per active step, a hand-over back, then the output register
//   load. One item is worked at a time; the next item can be taken once the
//   result is loaded, even if the receiver has not yet taken the result.
//   A zero step count skips the work: the load follows the accept directly.
//   A stalled receiver holds the result in the output register, and a second
//   finished result then waits inside the block until the first one is taken.
//   Reset (rst_n low, synchronous) empties the pipeline, clears the held step
//   and restores rate 1/16, eight steps, zero offsets and zero levels.
`include "tempo_synced_step_selector_defines.svh"

module tempo_synced_step_selector #(
  parameter int MAX_STEPS      = tssel_pkg::DEF_MAX_STEPS,
  parameter int TICKS_PER_BEAT = tssel_pkg::DEF_TICKS_PER_BEAT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tssel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tssel_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  tssel_in_if.sink                          in_chan,
  tssel_out_if.source                       out_chan
);
  import tssel_pkg::*;

  // Effective step limit: the registers only hold eight steps.
  localparam int CNT_LIM = (MAX_STEPS < REG_STEPS) ? MAX_STEPS : REG_STEPS;
  localparam int MAX_LEN = 16 * TICKS_PER_BEAT;  // 4/1 note in ticks
  localparam int STEP_W  = $clog2(MAX_LEN + 1);
  localparam int SEQ_W   = $clog2(CNT_LIM * MAX_LEN + 1);

  // Configuration registers
  logic [RATE_W-1:0] rate_r;
  logic [CNT_W-1:0]  count_r;
  logic [OFFS_W-1:0] offsets_r;
  logic [OFFS_W-1:0] levels_r;

  // Per-item work registers
  tssel_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]      n_r;
  logic [STEP_W-1:0]     len_r;
  logic [SEQ_W-1:0]      seqlen_r;
  logic                  hit_r;
  logic [STEP_IDX_W-1:0] hit_idx_r;

  // Held step state and output register
  logic [STEP_IDX_W-1:0] held_step_r, held_step_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  out_valid_r;
  logic [STEP_IDX_W-1:0] out_step_r;
  logic                  out_step_valid_r;
  logic [LVL_W-1:0]      out_level_r;
  logic                  out_matched_r;

  // Step length in ticks for every rate, floored, fixed at elaboration.
  logic [STEP_W-1:0] len_tab [NUM_RATES];

  for (genvar g = 0; g < NUM_RATES; g++) begin : g_len
    localparam int unsigned LEN_G = LEN96_TAB[g] * TICKS_PER_BEAT / 96;
    assign len_tab[g] = STEP_W'(LEN_G);
  end

  logic [RATE_W-1:0]       rate_idx;
  logic [STEP_W-1:0]       len_sel;
  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W+STEP_W-1:0] seq_prod;
  logic                    skip;
  logic                    accept;
  logic                    mod_start;
  logic                    mod_done;
  logic [SEQ_W-1:0]        mod_rem;
  logic                    scan_start;
  tssel_scan_res_t         scan_res;
  logic                    load_out;

  always_comb begin
    rate_idx = (rate_r < RATE_W'(NUM_RATES)) ? rate_r : RATE_W'(FALLBACK_RATE);
    len_sel  = len_tab[rate_idx];
    n_eff    = (count_r > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM) : count_r;
    seq_prod = n_eff * len_sel;
    // An empty sequence leaves the held step alone and reports no match.
    skip     = (n_eff == '0) || (len_sel == '0);
  end

  // Sequencer: accept, divide, scan, hand over to the output register.
  always_comb begin
    state_nxt  = state_r;
    accept     = 1'b0;
    mod_start  = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        accept = in_chan.valid;
        if (in_chan.valid) begin
          mod_start = !skip;
          state_nxt = skip ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Wait here while the previous result is still unclaimed.
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    held_step_nxt  = hit_r ? hit_idx_r : held_step_r;
    held_valid_nxt = hit_r | held_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RST_RATE;
      count_r   <= RST_COUNT;
      offsets_r <= '0;
      levels_r  <= '0;
    end else if (cfg_we) begin
      case (tssel_cfg_t'(cfg_index))
        CFG_RATE:    rate_r    <= cfg_wdata[RATE_W-1:0];
        CFG_COUNT:   count_r   <= cfg_wdata[CNT_W-1:0];
        CFG_OFFSETS: offsets_r <= cfg_wdata[OFFS_W-1:0];
        CFG_LEVELS:  levels_r  <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the item's geometry and the scan outcome.
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r      <= n_eff;
      len_r    <= len_sel;
      seqlen_r <= seq_prod[SEQ_W-1:0];
      hit_r    <= 1'b0;
    end else if ((state_r == S_SCAN) && scan_res.done) begin
      hit_r     <= scan_res.hit;
      hit_idx_r <= scan_res.idx;
    end
  end

  // Held step and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_step_r  <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load_out) begin
        held_step_r      <= held_step_nxt;
        held_valid_r     <= held_valid_nxt;
        out_valid_r      <= 1'b1;
        out_step_r       <= held_step_nxt;
        out_step_valid_r <= held_valid_nxt;
        out_level_r      <= held_valid_nxt ?
                            levels_r[held_step_nxt*LVL_W +: LVL_W] : '0;
        out_matched_r    <= hit_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  tssel_mod #(
    .SEQ_W (SEQ_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_chan.beat_position),
    .divisor  (seqlen_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  tssel_scan #(
    .STEP_W (STEP_W),
    .SEQ_W  (SEQ_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .n        (n_r),
    .step_len (len_r),
    .pos      (mod_rem),
    .offsets  (offsets_r),
    .res      (scan_res)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.step_index = out_step_r;
  assign out_chan.step_valid = out_step_valid_r;
  assign out_chan.step_level = out_level_r;
  assign out_chan.matched    = out_matched_r;

  `TSSEL_ASSERT(a_held_valid_sticks, clk, rst_n, held_valid_r |=> held_valid_r)
  `TSSEL_ASSERT(a_match_valid, clk, rst_n, (out_valid_r && out_matched_r) |-> out_step_valid_r)
  `TSSEL_ASSERT(a_mod_done_in_div, clk, rst_n, mod_done |-> (state_r == S_DIV))

endmodule

// ----- design/tssel_mod.sv -----
// Bit-serial floored remainder of a signed position by the sequence length.
// Depends on tssel_pkg and the macro header.
`include "tempo_synced_step_selector_defines.svh"

module tssel_mod #(
  parameter int SEQ_W = 17
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [tssel_pkg::POS_W-1:0] dividend,
  input  logic [SEQ_W-1:0]                  divisor,
  output logic                              done,
  output logic [SEQ_W-1:0]                  rem
);
  import tssel_pkg::*;

  localparam int ITER_W = $clog2(POS_W);

  logic [POS_W-1:0]  dvd_r;
  logic [SEQ_W-1:0]  rem_r;
  logic [ITER_W-1:0] iter_r;
  logic              busy_r;
  logic              fix_r;
  logic              neg_r;
  logic              done_r;

  logic [SEQ_W:0] trial;
  logic [SEQ_W:0] diff;
  logic           fits;

  // Shift in one dividend bit, subtract when the divisor fits.
  always_comb begin
    trial = {rem_r, dvd_r[POS_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(POS_W - 1);
        dvd_r  <= dividend[POS_W-1] ? POS_W'(-dividend) : POS_W'(dividend);
        neg_r  <= dividend[POS_W-1];
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[SEQ_W-1:0] : trial[SEQ_W-1:0];
        dvd_r  <= dvd_r << 1;
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == '0) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        // Floor: a negative position with a nonzero remainder folds back up.
        if (neg_r && (rem_r != '0)) begin
          rem_r <= divisor - rem_r;
        end
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `TSSEL_ASSERT(a_rem_below_divisor, clk, rst_n, done_r |-> (rem_r < divisor))
  `TSSEL_ASSERT_ALWAYS(a_busy_fix_exclusive, clk, !rst_n || !(busy_r && fix_r))

endmodule

// ----- design/tssel_scan.sv -----
// Step window scan: one step compared per cycle against the reduced position.
// Depends on tssel_pkg and the macro header.
`include "tempo_synced_step_selector_defines.svh"

module tssel_scan #(
  parameter int STEP_W = 15,
  parameter int SEQ_W  = 17
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tssel_pkg::CNT_W-1:0]        n,
  input  logic [STEP_W-1:0]                 step_len,
  input  logic [SEQ_W-1:0]                  pos,
  input  logic [tssel_pkg::OFFS_W-1:0]       offsets,
  output tssel_pkg::tssel_scan_res_t         res
);
  import tssel_pkg::*;

  // Room for 64 * (8 steps) * step length plus sign.
  localparam int CMP_W = STEP_W + 11;

  logic [STEP_IDX_W-1:0]   idx_r;
  logic signed [CMP_W-1:0] rel_r;   // 64*pos - 64*idx*len
  logic signed [CMP_W-1:0] prod_r;  // offset(idx) * len
  logic                    busy_r;
  logic                    hit_r;
  logic [STEP_IDX_W-1:0]   hit_idx_r;
  logic                    done_r;

  logic [STEP_IDX_W-1:0]   pick_idx;
  logic signed [OFF_W-1:0] off_b;
  logic signed [CMP_W-1:0] off_s;
  logic signed [CMP_W-1:0] len_s;
  logic signed [CMP_W-1:0] len64;
  logic signed [CMP_W-1:0] prod_nxt;
  logic                    in_win;
  logic                    last;

  always_comb begin
    pick_idx = start ? '0 : idx_r + STEP_IDX_W'(1);
    off_b    = offsets[pick_idx*OFF_W +: OFF_W];
    off_s    = CMP_W'(off_b);
    len_s    = CMP_W'(step_len);
    len64    = len_s <<< 6;
    prod_nxt = off_s * len_s;
    in_win   = (rel_r >= prod_r) && (rel_r < prod_r + len64);
    last     = (CNT_W'(idx_r) == n - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        hit_r  <= 1'b0;
        idx_r  <= '0;
        rel_r  <= CMP_W'({pos, 6'b0});
        prod_r <= prod_nxt;
      end else if (busy_r) begin
        // Later steps override earlier hits.
        if (in_win) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx_r;
        end
        rel_r  <= rel_r - len64;
        idx_r  <= idx_r + STEP_IDX_W'(1);
        prod_r <= prod_nxt;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.idx  = hit_idx_r;

  `TSSEL_ASSERT(a_hit_in_range, clk, rst_n, (done_r && hit_r) |-> (CNT_W'(hit_idx_r) < n))
  `TSSEL_ASSERT_ALWAYS(a_done_not_busy, clk, !rst_n || !(done_r && busy_r))

endmodule
